// File: sv/sfpr_pkg.sv
// ============================================================================
// sfpr_pkg: shared types and constants for the framed packet receiver
// Holds the parse phase encoding, result kinds and the result item layout.
// ============================================================================
package sfpr_pkg;

    // Frame sync bytes.
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Parse phases, one per field of the frame.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CNT   = 3'd3,
        PH_SYSID = 3'd4,
        PH_TYPE  = 3'd5,
        PH_DATA  = 3'd6,
        PH_CHECK = 3'd7
    } phase_t;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // One result item as it travels between the parser and the output stage.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] payload_index;
        logic [7:0] frame_sequence;
        logic [7:0] frame_length;
    } res_t;

    // Handshake between the parser and the output stage.
    typedef struct packed {
        logic valid;
        res_t data;
    } res_push_t;

endpackage

// File: sv/sfpr_if.sv
// ============================================================================
// sfpr_if: valid/ready channels of the framed packet receiver
// One channel carries received bytes in, the other carries result items out.
// ============================================================================
interface sfpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpr_res_if;
    logic              valid;
    logic              ready;
    sfpr_pkg::kind_t   kind;
    logic [7:0]        value;
    logic [7:0]        payload_index;
    logic [7:0]        frame_sequence;
    logic [7:0]        frame_length;

    modport source (output valid, output kind, output value, output payload_index,
                    output frame_sequence, output frame_length, input ready);
    modport sink   (input valid, input kind, input value, input payload_index,
                    input frame_sequence, input frame_length, output ready);
endinterface

// File: sv/sfpr_parser.sv
// ============================================================================
// sfpr_parser: input register and frame parsing state machine
// Registers each received byte, then steps the frame parser on it,
// producing at most one result item for the output stage.
// ============================================================================
module sfpr_parser (
    input  logic                clk,
    input  logic                rst_n,
    sfpr_rx_if.sink             rx_ch,
    input  logic                space,
    output sfpr_pkg::res_push_t push
);
    import sfpr_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       accept;
    logic       consume;
    logic       res_needed;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] rcvd_reg;
    logic [7:0] rcvd_next;
    logic [7:0] rcvd_inc;
    logic [7:0] seq_reg;
    logic [7:0] seq_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;

    // A result is only made in the payload and checksum phases.
    assign res_needed = (phase_reg == PH_DATA) || (phase_reg == PH_CHECK);
    assign consume    = s1_valid_reg && (!res_needed || space);
    assign rx_ch.ready = !s1_valid_reg || consume;
    assign accept     = rx_ch.valid && rx_ch.ready;
    assign rcvd_inc   = rcvd_reg + 8'd1;

    // Input register occupancy.
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (consume)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_byte_reg <= rx_ch.rx_byte;
    end

    // Next phase of the parser.
    always_comb
    begin
        phase_next = phase_reg;
        if (consume)
        begin
            case (phase_reg)
                PH_HUNT:  phase_next = (s1_byte_reg == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                PH_SYNC2: phase_next = (s1_byte_reg == SYNC_SECOND) ? PH_LEN : PH_HUNT;
                PH_LEN:   phase_next = PH_CNT;
                PH_CNT:   phase_next = PH_SYSID;
                PH_SYSID: phase_next = (s1_byte_reg != 8'd0) ? PH_TYPE : PH_SYSID;
                PH_TYPE:  phase_next = PH_DATA;
                PH_DATA:  phase_next = (rcvd_inc >= len_reg) ? PH_CHECK : PH_DATA;
                PH_CHECK: phase_next = PH_HUNT;
                default:  phase_next = PH_HUNT;
            endcase
        end
    end

    // Header fields, running sum and the result item.
    always_comb
    begin
        sum_next  = sum_reg;
        len_next  = len_reg;
        rcvd_next = rcvd_reg;
        seq_next  = seq_reg;
        type_next = type_reg;
        push.valid               = 1'b0;
        push.data.kind           = KIND_PAYLOAD;
        push.data.value          = s1_byte_reg;
        push.data.payload_index  = rcvd_reg;
        push.data.frame_sequence = seq_reg;
        push.data.frame_length   = len_reg;
        if (consume)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (s1_byte_reg == SYNC_FIRST)
                        sum_next = s1_byte_reg;
                end
                PH_SYNC2:
                begin
                    if (s1_byte_reg == SYNC_SECOND)
                        sum_next = sum_reg + s1_byte_reg;
                end
                PH_LEN:
                begin
                    len_next  = s1_byte_reg;
                    sum_next  = sum_reg + s1_byte_reg;
                    rcvd_next = 8'd0;
                end
                PH_CNT:
                begin
                    seq_next  = s1_byte_reg;
                    sum_next  = sum_reg + s1_byte_reg;
                    rcvd_next = 8'd0;
                end
                PH_SYSID:
                begin
                    sum_next  = sum_reg + s1_byte_reg;
                    rcvd_next = 8'd0;
                end
                PH_TYPE:
                begin
                    type_next = s1_byte_reg;
                    sum_next  = sum_reg + s1_byte_reg;
                    rcvd_next = 8'd0;
                end
                PH_DATA:
                begin
                    push.valid = 1'b1;
                    sum_next   = sum_reg + s1_byte_reg;
                    rcvd_next  = rcvd_inc;
                end
                PH_CHECK:
                begin
                    push.valid              = 1'b1;
                    push.data.kind          = (sum_reg == s1_byte_reg) ? KIND_GOOD : KIND_BAD;
                    push.data.value         = type_reg;
                    push.data.payload_index = 8'd0;
                end
                default:
                begin
                    push.valid = 1'b0;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            len_reg   <= 8'd0;
            rcvd_reg  <= 8'd0;
            seq_reg   <= 8'd0;
            type_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            rcvd_reg  <= rcvd_next;
            seq_reg   <= seq_next;
            type_reg  <= type_next;
        end
    end

`ifndef ASSERT_OFF
    // A result is only offered when the output stage has room for it.
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> space)
        else $error("parser offered an item with no room downstream");

    // Every checksum byte sends the parser back to hunting.
    a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && phase_reg == PH_CHECK) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after a checksum");

    // Payload count never passes the header length except for a zero length frame.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> ((rcvd_reg < len_reg) || (rcvd_reg == 8'd0)))
        else $error("payload count ran past the frame length");
`endif

endmodule

// File: sv/sfpr_out_stage.sv
// ============================================================================
// sfpr_out_stage: output register with skid entry
// Holds result items for the sink so that a stalled sink never stops the
// parser from taking the next byte while one item waits.
// ============================================================================
module sfpr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  sfpr_pkg::res_push_t push,
    output logic                space,
    sfpr_res_if.source          res_ch
);
    import sfpr_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_data_reg;
    res_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_data_reg;
    res_t skid_data_next;
    logic pop;

    assign space = !skid_valid_reg;
    assign pop   = out_valid_reg && res_ch.ready;

    // Drive the result channel from the output register.
    assign res_ch.valid          = out_valid_reg;
    assign res_ch.kind           = out_data_reg.kind;
    assign res_ch.value          = out_data_reg.value;
    assign res_ch.payload_index  = out_data_reg.payload_index;
    assign res_ch.frame_sequence = out_data_reg.frame_sequence;
    assign res_ch.frame_length   = out_data_reg.frame_length;

    // Move items between the parser, the skid entry and the output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push.valid)
            begin
                out_data_next = push.data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (out_valid_reg)
            begin
                skid_data_next  = push.data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = push.data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    // The skid entry is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    // With nothing waiting and nothing arriving, a taken item empties the stage.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push.valid) |=> !out_valid_reg)
        else $error("output register kept an item that was already taken");

    // A waiting skid item moves forward as soon as the head is taken.
    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid item did not advance after the head was taken");
`endif

endmodule

// File: sv/sync_framed_packet_receiver.sv
// ============================================================================
// sync_framed_packet_receiver: serial frame deframer with additive checksum
// Parses 0xAA 0x55 length count sysid type payload checksum frames, reports
// each payload byte and a good or bad verdict on the checksum byte.
// ============================================================================
//
//   Channel   Direction  Fields
//   rx_ch     in         rx_byte
//   res_ch    out        kind, value, payload_index, frame_sequence,
//                        frame_length
//
// One byte is taken every cycle unless rx_ch.ready falls as below; each byte's
// result passes through the input register, then the output register.
// Reset clears the parser to hunting with all header state at zero.
// A stalled sink fills the output register and then a skid entry; rx_ch.ready
// falls only when both hold items and the next byte would produce a result.
//
module sync_framed_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    sfpr_rx_if.sink     rx_ch,
    sfpr_res_if.source  res_ch
);
    import sfpr_pkg::*;

    logic      space;
    res_push_t push;

    // Input register and frame parser.
    sfpr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .rx_ch (rx_ch),
        .space (space),
        .push  (push)
    );

    // Output register with skid entry.
    sfpr_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space  (space),
        .res_ch (res_ch)
    );

endmodule

// File: test/tb_sync_framed_packet_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sync_framed_packet_receiver: self-checking bench for the frame deframer
// Feeds received bytes through the input channel and predicts every payload
// item and checksum verdict with a behavioural parser of its own. Directed
// frames and broken sync sequences come first. Randomised frames, truncated
// frames and line noise follow under several sender and receiver idling
// patterns, and a long receiver hold-off makes the block stall its input.
// ============================================================================
module tb_sync_framed_packet_receiver;

    import sfpr_pkg::*;

    logic clk;
    logic rst_n;

    sfpr_rx_if  rx_ch ();
    sfpr_res_if res_ch ();

    sync_framed_packet_receiver u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_ch  (rx_ch),
        .res_ch (res_ch)
    );

    // Predicted parser state.
    phase_t     pred_phase;
    logic [7:0] pred_sum;
    logic [7:0] pred_length;
    logic [7:0] pred_received;
    logic [7:0] pred_sequence;
    logic [7:0] pred_type;

    // Result items still to come out of the block, oldest first.
    res_t pending_results[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_left      = 0;
    int frame_items    = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Guard against a hung run.
    initial
    begin
        #5_000_000;
        $display("sync_framed_packet_receiver: mismatch");
        $finish;
    end

    // Record one failure; only the first few are described.
    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // Advance the predicted parser by one received byte and queue any result.
    function automatic void deframe_byte(input logic [7:0] b);
        res_t r;
        case (pred_phase)
            PH_HUNT:
            begin
                if (b == SYNC_FIRST)
                begin
                    pred_sum   = b;
                    pred_phase = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    pred_sum   = pred_sum + b;
                    pred_phase = PH_LEN;
                end
                else
                begin
                    pred_phase = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                pred_length   = b;
                pred_sum      = pred_sum + b;
                pred_received = 8'd0;
                pred_phase    = PH_CNT;
            end
            PH_CNT:
            begin
                pred_sequence = b;
                pred_sum      = pred_sum + b;
                pred_received = 8'd0;
                pred_phase    = PH_SYSID;
            end
            PH_SYSID:
            begin
                // A zero id keeps the parser here, but the byte is still summed.
                if (b != 8'd0)
                begin
                    pred_phase = PH_TYPE;
                end
                pred_sum      = pred_sum + b;
                pred_received = 8'd0;
            end
            PH_TYPE:
            begin
                pred_type     = b;
                pred_sum      = pred_sum + b;
                pred_received = 8'd0;
                pred_phase    = PH_DATA;
            end
            PH_DATA:
            begin
                r.kind           = KIND_PAYLOAD;
                r.value          = b;
                r.payload_index  = pred_received;
                r.frame_sequence = pred_sequence;
                r.frame_length   = pred_length;
                pending_results.push_back(r);
                pred_sum      = pred_sum + b;
                pred_received = pred_received + 8'd1;
                // A zero length still takes one payload byte.
                if (pred_received >= pred_length)
                begin
                    pred_phase = PH_CHECK;
                end
            end
            default:
            begin
                // Checksum byte: not summed, always back to hunting.
                r.kind           = (pred_sum == b) ? KIND_GOOD : KIND_BAD;
                r.value          = pred_type;
                r.payload_index  = 8'd0;
                r.frame_sequence = pred_sequence;
                r.frame_length   = pred_length;
                pending_results.push_back(r);
                pred_phase = PH_HUNT;
            end
        endcase
    endfunction

    // Offer one item, idling first at the current rate, and wait for it to go.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        deframe_byte(b);
    endtask

    // Build a frame with a correct or corrupted checksum, optionally cut short.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] seq,
                              input int zero_ids, input logic [7:0] sysid,
                              input logic [7:0] ftype, input logic [7:0] fill,
                              input bit rand_fill, input bit good, input int keep);
        logic [7:0] frame[$];
        logic [7:0] sum;
        logic [7:0] pb;
        logic [7:0] skew;
        int n;
        frame = {SYNC_FIRST, SYNC_SECOND, len, seq};
        repeat (zero_ids) frame.push_back(8'd0);
        frame.push_back(sysid);
        frame.push_back(ftype);
        n = (len == 8'd0) ? 1 : int'(len);
        repeat (n)
        begin
            pb = rand_fill ? 8'($urandom_range(255)) : fill;
            frame.push_back(pb);
        end
        sum = 8'd0;
        foreach (frame[i]) sum = sum + frame[i];
        skew = 8'($urandom_range(1, 255));
        frame.push_back(good ? sum : sum + skew);
        if (keep > 0)
        begin
            while (frame.size() > keep) void'(frame.pop_back());
        end
        frame_items += frame.size();
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare every accepted result item with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            check_result();
        end
    end

    function automatic void check_result();
        res_t want;
        res_t got;
        got.kind           = res_ch.kind;
        got.value          = res_ch.value;
        got.payload_index  = res_ch.payload_index;
        got.frame_sequence = res_ch.frame_sequence;
        got.frame_length   = res_ch.frame_length;
        if (pending_results.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected item kind %0d value %02h idx %0d seq %02h len %0d",
                                    got.kind, got.value, got.payload_index,
                                    got.frame_sequence, got.frame_length));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.value !== want.value
                || got.payload_index !== want.payload_index
                || got.frame_sequence !== want.frame_sequence
                || got.frame_length !== want.frame_length)
            begin
                flag_mismatch($sformatf({"expected kind %0d value %02h idx %0d seq %02h len %0d,",
                                         " got kind %0d value %02h idx %0d seq %02h len %0d"},
                                        want.kind, want.value, want.payload_index,
                                        want.frame_sequence, want.frame_length,
                                        got.kind, got.value, got.payload_index,
                                        got.frame_sequence, got.frame_length));
            end
        end
    endfunction

    // Sync edge cases, a zero-length frame and a bad checksum at field extremes.
    task automatic test_directed_frames();
        send_idle_pct = 0;
        stall_pct     = 0;
        // Wrong second sync byte.
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // A repeated first sync byte is not taken as a new start.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // Zero length with a zero system id first; good checksum.
        send_frame(8'h00, 8'hFF, 1, 8'h01, 8'hFF, 8'hFF, 1'b0, 1'b1, 0);
        // One payload byte, all-ones id, bad checksum.
        send_frame(8'h01, 8'h00, 0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 0);
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise.
    task automatic run_random_frames(input int idle_pct, input int stall, input int goal);
        int start;
        int pick;
        int zeros;
        logic [7:0] len;
        logic [7:0] noise;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = frame_items;
        while (frame_items - start < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                len = 8'($urandom_range(128, 255));
            end
            else if (pick < 12)
            begin
                len = 8'd0;
            end
            else
            begin
                len = 8'($urandom_range(1, 12));
            end
            zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            pick  = $urandom_range(99);
            if (pick < 80)
            begin
                send_frame(len, 8'($urandom_range(255)), zeros, 8'($urandom_range(1, 255)),
                           8'($urandom_range(255)), 8'h00, 1'b1,
                           $urandom_range(99) < 70, 0);
            end
            else if (pick < 90)
            begin
                // Frame cut off somewhere before its checksum.
                send_frame(len, 8'($urandom_range(255)), zeros, 8'($urandom_range(1, 255)),
                           8'($urandom_range(255)), 8'h00, 1'b1, 1'b1,
                           $urandom_range(2, 6 + zeros));
            end
            else
            begin
                // Line noise, with the first sync byte more likely than chance.
                repeat ($urandom_range(1, 4))
                begin
                    noise = ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom_range(255));
                    send_byte(noise);
                end
            end
        end
    endtask

    task automatic test_streaming();
        run_random_frames(0, 0, 280);
    endtask

    task automatic test_sender_gaps();
        run_random_frames(77, 0, 280);
    endtask

    task automatic test_receiver_stalls();
        run_random_frames(0, 77, 280);
    endtask

    task automatic test_both_idle();
        run_random_frames(36, 36, 280);
    endtask

    // Long receiver hold-off during a maximum-length frame so the input backs up.
    task automatic test_long_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 400;
        send_frame(8'hFF, 8'($urandom_range(255)), 0, 8'($urandom_range(1, 255)),
                   8'($urandom_range(255)), 8'h00, 1'b1, 1'b1, 0);
    endtask

    // Drain outstanding results, then give the verdict.
    task automatic finish_run();
        int waited;
        waited = 0;
        rx_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            flag_mismatch($sformatf("%0d expected items never arrived",
                                    pending_results.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("sync_framed_packet_receiver: match");
        end
        else
        begin
            $display("sync_framed_packet_receiver: mismatch");
        end
        $finish;
    endtask

    // Reset, then each test in turn.
    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        res_ch.ready   = 1'b0;
        pred_phase     = PH_HUNT;
        pred_sum       = 8'd0;
        pred_length    = 8'd0;
        pred_received  = 8'd0;
        pred_sequence  = 8'd0;
        pred_type      = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_streaming();
        test_sender_gaps();
        test_long_hold();
        test_receiver_stalls();
        test_both_idle();
        finish_run();
    end

endmodule
